// File: rtl/ccap_pkg.sv
`timescale 1ns / 1ps

package ccap_pkg;

	// field widths
	localparam int FUNC_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int REGION_W = 10;
	localparam int RUN_W    = 33;
	localparam int TOTAL_W  = 40;

	// request kinds
	localparam logic [FUNC_W-1:0] FUNC_ENTRY = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// saturation limits
	localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// one request held in the input stage
	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic                first_of_origin;
		logic [VALUE_W-1:0]  supply;
		logic [VALUE_W-1:0]  demand;
		logic [REGION_W-1:0] region;
		logic                in_range;
	} item_t;

	// one result
	typedef struct packed {
		logic               included;
		logic [TOTAL_W-1:0] region_total;
		logic               saturated;
	} result_t;

	// write into the region total store
	typedef struct packed {
		logic                en;
		logic [REGION_W-1:0] region;
		logic [TOTAL_W-1:0]  data;
	} wr_req_t;

endpackage

// File: rtl/ccap_store.sv
`timescale 1ns / 1ps

module ccap_store #(
	parameter int DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [ccap_pkg::REGION_W-1:0]  rd_region,
	input  ccap_pkg::wr_req_t              wr,
	output logic [ccap_pkg::TOTAL_W-1:0]   rd_data,
	output logic                           busy
);
	import ccap_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [TOTAL_W-1:0]  mem [DEPTH];
	logic [TOTAL_W-1:0]  rd_q;
	logic [REGION_W-1:0] rd_region_q;
	logic                clearing_q;
	logic [AW-1:0]       clr_idx_q;
	logic                fwd_valid_q;
	logic [REGION_W-1:0] fwd_region_q;
	logic [TOTAL_W-1:0]  fwd_data_q;

	logic                we;
	logic [AW-1:0]       waddr;
	logic [TOTAL_W-1:0]  wdata;

	// the clearing sweep owns the write port after reset
	assign we    = clearing_q | wr.en;
	assign waddr = clearing_q ? clr_idx_q : wr.region[AW-1:0];
	assign wdata = clearing_q ? '0 : wr.data;
	assign busy  = clearing_q;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q        <= mem[rd_region[AW-1:0]];
			rd_region_q <= rd_region;
		end
	end

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// last write, for a read issued on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr.en && !clearing_q) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && !clearing_q) begin
			fwd_region_q <= wr.region;
			fwd_data_q   <= wr.data;
		end
	end

	// forward the newest value of the address
	assign rd_data = (fwd_valid_q && fwd_region_q == rd_region_q) ? fwd_data_q : rd_q;

endmodule

// File: rtl/ccap_update.sv
`timescale 1ns / 1ps

module ccap_update (
	input  ccap_pkg::item_t                item,
	input  logic [ccap_pkg::TOTAL_W-1:0]   old_total,
	input  logic [ccap_pkg::RUN_W-1:0]     run_q,
	output ccap_pkg::result_t              res,
	output ccap_pkg::wr_req_t              wr,
	output logic                           run_we,
	output logic [ccap_pkg::RUN_W-1:0]     run_next
);
	import ccap_pkg::*;

	logic [RUN_W-1:0]   prior_sum;
	logic [RUN_W:0]     after_w;
	logic               inc;
	logic [TOTAL_W:0]   sum_w;
	logic [TOTAL_W-1:0] clip;
	logic               ovf;

	// running demand of the current origin
	assign prior_sum = item.first_of_origin ? '0 : run_q;
	assign after_w   = {1'b0, prior_sum} + (RUN_W + 1)'(item.demand);
	assign run_next  = after_w[RUN_W] ? RUN_MAX : after_w[RUN_W-1:0];
	assign inc       = prior_sum <= RUN_W'(item.supply);

	// saturating add into the region total
	assign sum_w = {1'b0, old_total} + (TOTAL_W + 1)'(item.demand);
	assign ovf   = sum_w[TOTAL_W];
	assign clip  = ovf ? TOTAL_MAX : sum_w[TOTAL_W-1:0];

	// per-kind result and table write
	always_comb begin
		res       = '0;
		wr.en     = 1'b0;
		wr.region = item.region;
		wr.data   = '0;
		run_we    = 1'b0;
		case (item.func)
			FUNC_ENTRY: begin
				run_we       = 1'b1;
				res.included = inc;
				if (item.in_range) begin
					res.region_total = inc ? clip : old_total;
					res.saturated    = inc & ovf;
					wr.en            = inc;
					wr.data          = clip;
				end
			end
			FUNC_READ: begin
				if (item.in_range) begin
					res.region_total = old_total;
					res.saturated    = old_total == TOTAL_MAX;
				end
			end
			FUNC_CLEAR: begin
				wr.en = item.in_range;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

// File: rtl/catchment_capacity_accumulator.sv
`timescale 1ns / 1ps
// channel | dir | tdata                                   | tuser
// s_*     | in  | supply[31:0] demand[63:32] region[73:64] | func[1:0] first_of_origin[2]
// m_*     | out | region_total[39:0]                      | included[0] saturated[1]
//
// one request per cycle sustained while m_tready is high; the output is registered
// region total read-modify-write, in order: registered table read
// on acceptance, add in the input stage, write on the edge the request moves on
// after reset the table is swept to zero, one entry a cycle, with s_tready low
// a stalled result holds in the output register; the input stage holds one more

module catchment_capacity_accumulator #(
	parameter int NUM_REGIONS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // supply, demand, region, zero pad
	input  logic [2:0]  s_tuser,   // func, first_of_origin
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // region_total
	output logic [1:0]  m_tuser    // included, saturated
);
	import ccap_pkg::*;

	localparam int DEPTH = (NUM_REGIONS < (1 << REGION_W)) ? NUM_REGIONS : (1 << REGION_W);

	item_t              in_item;
	item_t              item_s1;
	logic               valid_s1;
	logic               adv_s1;
	logic               s_accept;
	logic               busy;
	logic [RUN_W-1:0]   run_q;
	logic [TOTAL_W-1:0] old_total;
	result_t            res;
	wr_req_t            wr_calc;
	wr_req_t            wr;
	logic               run_we;
	logic [RUN_W-1:0]   run_next;
	result_t            res_s2;
	logic               valid_s2;

	// unpack the input request
	always_comb begin
		in_item.func            = s_tuser[1:0];
		in_item.first_of_origin = s_tuser[2];
		in_item.supply          = s_tdata[31:0];
		in_item.demand          = s_tdata[63:32];
		in_item.region          = s_tdata[73:64];
		in_item.in_range        = 32'(s_tdata[73:64]) < NUM_REGIONS;
	end

	// handshake
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !busy && (!valid_s1 || adv_s1);
	assign s_accept = s_tvalid && s_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= in_item;
		end
	end

	// region total table
	assign wr.en     = wr_calc.en && adv_s1;
	assign wr.region = wr_calc.region;
	assign wr.data   = wr_calc.data;

	ccap_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (s_accept && in_item.in_range),
		.rd_region (in_item.region),
		.wr        (wr),
		.rd_data   (old_total),
		.busy      (busy)
	);

	ccap_update u_update (
		.item      (item_s1),
		.old_total (old_total),
		.run_q     (run_q),
		.res       (res),
		.wr        (wr_calc),
		.run_we    (run_we),
		.run_next  (run_next)
	);

	// running demand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (adv_s1 && run_we) begin
			run_q <= run_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.region_total;
	assign m_tuser  = {res_s2.saturated, res_s2.included};

endmodule

// File: rtl/ccap_checker.sv
`timescale 1ns / 1ps

module ccap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [79:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a saturated total stands at full scale
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 40'hFF_FFFF_FFFF)
		else $error("saturated flag without full scale total");

	// every accepted request is followed by a valid result on the output
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("accepted request gave no result");

endmodule

bind catchment_capacity_accumulator ccap_checker u_ccap_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
